/* design/e2q_pkg.sv */
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int AngleWidth = 16;
  localparam int QuatFracBits = 14;
  localparam int QuatWidth = QuatFracBits + 2;
  localparam int CordicIters = 16;
  localparam int Frac = 30;
  localparam int VecWidth = 34;
  localparam int IterWidth = $clog2(CordicIters);
  localparam logic signed [VecWidth-1:0] CordicGain = 34'sd652032874;
  localparam logic [16:0] DegPeriod = 17'd46080;
  localparam logic [16:0] Quarter = 17'd11520;

  typedef enum logic [1:0] {
    CMD_ALL  = 2'd0,
    CMD_YAW  = 2'd1,
    CMD_PITCH = 2'd2,
    CMD_ROLL = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROT,
    ST_SAVE,
    ST_PROD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic [IterWidth-1:0] iter;
  } cordic_ctrl_t;

  function automatic logic signed [VecWidth-1:0] atan_entry(input logic [IterWidth-1:0] i);
    logic signed [VecWidth-1:0] r;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      10: r = 34'sd1048575;
      default: r = (34'sd1 <<< (Frac - 32'(i))) - 34'sd1;
    endcase
    return r;
  endfunction
endpackage

/* design/e2q_cordic.sv */
`timescale 1ns / 1ps
module e2q_cordic (
  input  logic clk_i,
  input  logic rst_ni,
  input  e2q_pkg::cordic_ctrl_t ctrl_i,
  input  logic signed [e2q_pkg::AngleWidth-1:0] deg_i,
  output logic signed [e2q_pkg::VecWidth-1:0] sin_o,
  output logic signed [e2q_pkg::VecWidth-1:0] cos_o
);
  import e2q_pkg::*;

  logic signed [VecWidth-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic neg_q, neg_d;
  logic [16:0] m;
  logic signed [17:0] u;
  logic [16:0] mag;
  logic [50:0] zp;
  logic signed [VecWidth-1:0] z0;
  logic signed [17:0] degx;

  always_comb begin
    degx = 18'(deg_i);
    // Reduce modulo 720 degrees: magnitude below two periods after offset.
    m = 17'(degx + 18'sd46080);
    if (m >= DegPeriod) m = m - DegPeriod;
    u = 18'($signed({1'b0, m}));
    if (m <= Quarter) begin
      u = $signed({1'b0, m});
    end else if (m < 17'd34560) begin
      u = $signed({1'b0, m}) - 18'sd23040;
    end else begin
      u = $signed({1'b0, m}) - 18'sd46080;
    end
    mag = u[17] ? 17'(-u) : 17'(u);
    zp = (51'(mag) * 51'd9595049034 + 51'd32768) >> 16;
    z0 = u[17] ? -VecWidth'(zp) : VecWidth'(zp);
  end

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q;
    neg_d = neg_q;
    if (ctrl_i.start) begin
      x_d = CordicGain; y_d = '0; z_d = z0;
      neg_d = (m > Quarter) && (m < 17'd34560);
    end else if (ctrl_i.step) begin
      if (!z_q[VecWidth-1]) begin
        x_d = x_q - (y_q >>> ctrl_i.iter);
        y_d = y_q + (x_q >>> ctrl_i.iter);
        z_d = z_q - atan_entry(ctrl_i.iter);
      end else begin
        x_d = x_q + (y_q >>> ctrl_i.iter);
        y_d = y_q - (x_q >>> ctrl_i.iter);
        z_d = z_q + atan_entry(ctrl_i.iter);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else begin
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign cos_o = neg_q ? -x_q : x_q;
  assign sin_o = neg_q ? -y_q : y_q;
endmodule

/* design/euler_to_quaternion.sv */
`timescale 1ns / 1ps
// Converts yaw, pitch and roll to a unit quaternion in Q1.14. A request
// updates all three held angles or one of them, in Q9.6 degrees or Q3.12
// radians. One request keeps the block busy through three passes of the
// shared CORDIC rotator (load, sixteen rotations, capture), sixteen
// products on the shared multiplier and a final state that posts the
// result. Stall is high for the whole of that time. A waiting result
// does not block the next request; only the product phase of that
// request waits until the result is taken.
module euler_to_quaternion (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic signed [15:0] angle_x_i,
  input  logic signed [15:0] angle_y_i,
  input  logic signed [15:0] angle_z_i,
  input  logic in_degrees_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o
);
  import e2q_pkg::*;

  state_e state_q, state_d;
  logic [IterWidth-1:0] iter_q, iter_d;
  logic [1:0] ang_q, ang_d;
  logic [3:0] pidx_q, pidx_d;
  logic signed [AngleWidth-1:0] yaw_q, pitch_q, roll_q, yaw_d, pitch_d, roll_d;
  logic signed [VecWidth-1:0] sv [3], cv [3];
  logic signed [VecWidth-1:0] s_o, c_o;
  logic signed [VecWidth-1:0] ab_q, acc_q, acc_d;
  logic signed [63:0] prod;
  logic signed [VecWidth-1:0] ma, mb, prnd;
  logic signed [QuatWidth-1:0] q_q [4];
  logic signed [QuatWidth-1:0] fin;
  logic signed [AngleWidth-1:0] cdeg;
  logic signed [35:0] rtmp;
  logic accept, out_valid_q, out_valid_d;
  cordic_ctrl_t cctl;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  function automatic logic signed [AngleWidth-1:0] to_deg(
      input logic signed [AngleWidth-1:0] a, input logic dg);
    logic signed [35:0] p;
    if (dg) return a;
    p = (36'(a) * 36'sd58671 + 36'sd32768) >>> 16;
    if (p > 36'sd32767) return 16'sh7fff;
    if (p < -36'sd32768) return 16'sh8000;
    return 16'(p);
  endfunction

  always_comb begin
    yaw_d = yaw_q; pitch_d = pitch_q; roll_d = roll_q;
    if (accept) begin
      if (cmd_i == CMD_ALL || cmd_i == CMD_YAW) yaw_d = to_deg(angle_x_i, in_degrees_i);
      if (cmd_i == CMD_ALL || cmd_i == CMD_PITCH) pitch_d = to_deg(angle_y_i, in_degrees_i);
      if (cmd_i == CMD_ALL || cmd_i == CMD_ROLL) roll_d = to_deg(angle_z_i, in_degrees_i);
    end
  end

  always_comb begin
    case (ang_q)
      2'd0: cdeg = yaw_q;
      2'd1: cdeg = pitch_q;
      default: cdeg = roll_q;
    endcase
  end

  e2q_cordic u_cordic (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (cctl), .deg_i (cdeg),
    .sin_o (s_o), .cos_o (c_o)
  );

  // Product schedule: sixteen terms, index bits pick roll, pitch, yaw factor.
  // Term t = 4*k + j: k is the component, j odd steps finish a triple.
  logic [2:0] sel; // bit2 roll sine, bit1 pitch sine, bit0 yaw sine
  logic [1:0] comp;
  logic second, neg_term;
  always_comb begin
    comp = pidx_q[3:2];
    second = pidx_q[1];
    case (comp)
      2'd0: sel = second ? 3'b011 : 3'b100;
      2'd1: sel = second ? 3'b101 : 3'b010;
      2'd2: sel = second ? 3'b110 : 3'b001;
      default: sel = second ? 3'b111 : 3'b000;
    endcase
    neg_term = second && (comp == 2'd0 || comp == 2'd2);
    if (!pidx_q[0]) begin
      ma = sel[2] ? sv[2] : cv[2];
      mb = sel[1] ? sv[1] : cv[1];
    end else begin
      ma = ab_q;
      mb = sel[0] ? sv[0] : cv[0];
    end
    prod = 64'(ma) * 64'(mb);
    rtmp = 36'((prod + (64'sd1 <<< (Frac - 1))) >>> Frac);
    prnd = VecWidth'(rtmp);
  end

  always_comb begin
    logic signed [VecWidth-1:0] r;
    acc_d = acc_q;
    if (pidx_q[0]) acc_d = (second ? acc_q : '0) + (neg_term ? -prnd : prnd);
    r = (acc_d + (VecWidth'(1) <<< (Frac - QuatFracBits - 1))) >>> (Frac - QuatFracBits);
    if (r > (VecWidth'(1) <<< QuatFracBits)) fin = QuatWidth'(1 <<< QuatFracBits);
    else if (r < -(VecWidth'(1) <<< QuatFracBits)) fin = -QuatWidth'(1 <<< QuatFracBits);
    else fin = QuatWidth'(r);
  end

  always_comb begin
    state_d = state_q; iter_d = iter_q; ang_d = ang_q; pidx_d = pidx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cctl = '0;
    cctl.iter = iter_q;
    case (state_q)
      ST_IDLE: if (accept) begin state_d = ST_PREP; ang_d = 2'd0; end
      ST_PREP: begin cctl.start = 1'b1; iter_d = '0; state_d = ST_ROT; end
      ST_ROT: begin
        cctl.step = 1'b1;
        iter_d = iter_q + 1'b1;
        if (iter_q == IterWidth'(CordicIters - 1)) state_d = ST_SAVE;
      end
      ST_SAVE: begin
        // The products overwrite the result registers, so they wait for
        // the previous result to be taken.
        if (ang_q != 2'd2 || !out_valid_q) begin
          ang_d = ang_q + 2'd1;
          pidx_d = '0;
          state_d = (ang_q == 2'd2) ? ST_PROD : ST_PREP;
        end
      end
      ST_PROD: begin
        pidx_d = pidx_q + 4'd1;
        if (pidx_q == 4'd15) state_d = ST_DONE;
      end
      ST_DONE: begin out_valid_d = 1'b1; state_d = ST_IDLE; end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; iter_q <= '0; ang_q <= '0; pidx_q <= '0;
      out_valid_q <= 1'b0;
      yaw_q <= '0; pitch_q <= '0; roll_q <= '0;
    end else begin
      state_q <= state_d; iter_q <= iter_d; ang_q <= ang_d; pidx_q <= pidx_d;
      out_valid_q <= out_valid_d;
      yaw_q <= yaw_d; pitch_q <= pitch_d; roll_q <= roll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SAVE) begin
      sv[ang_q] <= s_o;
      cv[ang_q] <= c_o;
    end
    if (state_q == ST_PROD) begin
      if (!pidx_q[0]) ab_q <= prnd;
      acc_q <= acc_d;
      if (pidx_q[1:0] == 2'd3) q_q[comp] <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quat_x_o = q_q[0];
  assign quat_y_o = q_q[1];
  assign quat_z_o = q_q[2];
  assign quat_w_o = q_q[3];

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("stall low while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> out_valid_o) else $error("no result after done");
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_PREP)) else $error("request not started");
endmodule
